@@ rtl/core/sad_pkg.sv @@
// shared constants, types and helpers of the series allpass diffuser
package sad_pkg;

  // sample and gain formats
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned GAIN_BITS   = 16;
  localparam int unsigned DELAY_BITS  = 10;

  // stages and circular buffers
  localparam int unsigned STAGE_COUNT  = 4;
  localparam int unsigned BUFFER_DEPTH = 1024;
  localparam int unsigned STAGE_BITS   = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam int unsigned PTR_BITS     = $clog2(BUFFER_DEPTH);
  localparam int unsigned ADDR_BITS    = STAGE_BITS + PTR_BITS;
  localparam int unsigned RAM_DEPTH    = (1 << ADDR_BITS);

  // datapath widths
  localparam int unsigned PROD_BITS  = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int unsigned SCALE_BITS = PROD_BITS - GAIN_BITS;
  localparam int unsigned SUM_BITS   = SAMPLE_BITS + 2;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = GAIN_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GAIN    = 3'd0,
    REG_DELAY_A = 3'd1,
    REG_DELAY_B = 3'd2,
    REG_DELAY_C = 3'd3,
    REG_DELAY_D = 3'd4
  } cfg_reg_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [ADDR_BITS-1:0]   addr_t;

  // buffer memory request, one read and one write port
  typedef struct packed {
    logic    we;
    addr_t   waddr;
    sample_t wdata;
    logic    re;
    addr_t   raddr;
  } ram_req_t;

  // clamp a widened sum to the sample range
  function automatic sample_t sat(input logic signed [SUM_BITS-1:0] v);
    sample_t r;
    if ((v[SUM_BITS-1:SAMPLE_BITS-1] == '0) || (v[SUM_BITS-1:SAMPLE_BITS-1] == '1)) begin
      r = v[SAMPLE_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ rtl/core/sad_stream_if.sv @@
// valid/ready stream interfaces for input and result samples
interface sad_in_if;
  logic             valid;
  logic             ready;
  sad_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface sad_out_if;
  logic             valid;
  logic             ready;
  sad_pkg::sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

@@ rtl/core/sad_buffer_ram.sv @@
// delay buffer memory for all stages, one write and one registered read per cycle
module sad_buffer_ram (
  input  logic                clk_i,
  input  sad_pkg::ram_req_t   req_i,
  output sad_pkg::sample_t    rdata_o
);

  sad_pkg::sample_t mem [sad_pkg::RAM_DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

@@ rtl/core/series_allpass_diffuser.sv @@
// four-stage allpass diffuser: sequencer, shared multiply-add datapath and buffer memory
//
//   port        dir  beat / write             payload
//   in_i        in   valid & ready            sample_in  (24-bit signed)
//   out_o       out  valid & ready            sample_out (24-bit signed)
//   cfg_*       in   cfg_we_i high            cfg_idx_i, cfg_data_i
//
// each item passes the idle state, then five steps per stage (read, multiply,
// add and write back, multiply, subtract), an order set by the single shared multiplier
// and the one read port of the buffer memory.
// the result register frees the datapath, so the next beat is taken while a
// result waits; a finished item only waits if the result register is still full.
// after reset no clearing pass runs: entries not yet written since reset read as zero.
module series_allpass_diffuser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sad_in_if.sink                              in_i,
  sad_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [sad_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [sad_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL1,
    S_ADD1,
    S_MUL2,
    S_ADD2,
    S_HOLD
  } state_e;

  localparam logic [sad_pkg::STAGE_BITS-1:0] LastStage =
    sad_pkg::STAGE_BITS'(sad_pkg::STAGE_COUNT - 1);
  localparam logic [sad_pkg::PTR_BITS-1:0] LastPtr =
    sad_pkg::PTR_BITS'(sad_pkg::BUFFER_DEPTH - 1);

  state_e                             state_q;
  logic [sad_pkg::STAGE_BITS-1:0]     stage_q;
  logic [sad_pkg::PTR_BITS-1:0]       wp_q;
  logic                               wrapped_q;
  logic                               rvalid_q;
  logic                               out_valid_q;
  sad_pkg::sample_t                   out_data_q;

  logic [sad_pkg::GAIN_BITS-1:0]      gain_q;
  logic [sad_pkg::DELAY_BITS-1:0]     delay_q [sad_pkg::STAGE_COUNT];

  sad_pkg::sample_t                   x_q;
  sad_pkg::sample_t                   old_q;
  sad_pkg::sample_t                   v_q;
  logic signed [sad_pkg::PROD_BITS-1:0] prod_q;

  sad_pkg::ram_req_t                  ram_req;
  sad_pkg::sample_t                   ram_rdata;

  logic [sad_pkg::PTR_BITS-1:0]       rd_idx;
  logic                               rd_valid;
  sad_pkg::sample_t                   old_val;
  sad_pkg::sample_t                   mul_a;
  logic signed [sad_pkg::PROD_BITS-1:0] prod_d;
  logic signed [sad_pkg::SCALE_BITS-1:0] scaled;
  sad_pkg::sample_t                   v_d;
  sad_pkg::sample_t                   x_d;
  logic                               out_free;
  logic                               out_load;
  logic                               in_beat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
      for (int i = 0; i < sad_pkg::STAGE_COUNT; i++) begin
        delay_q[i] <= sad_pkg::DELAY_BITS'(1);
      end
    end else if (cfg_we_i) begin
      unique case (sad_pkg::cfg_reg_e'(cfg_idx_i))
        sad_pkg::REG_GAIN:    gain_q     <= cfg_data_i;
        sad_pkg::REG_DELAY_A: delay_q[0] <= cfg_data_i[sad_pkg::DELAY_BITS-1:0];
        sad_pkg::REG_DELAY_B: delay_q[1] <= cfg_data_i[sad_pkg::DELAY_BITS-1:0];
        sad_pkg::REG_DELAY_C: delay_q[2] <= cfg_data_i[sad_pkg::DELAY_BITS-1:0];
        sad_pkg::REG_DELAY_D: delay_q[3] <= cfg_data_i[sad_pkg::DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read index and whether that entry was written since reset
  assign rd_idx   = wp_q - sad_pkg::PTR_BITS'(delay_q[stage_q]);
  assign rd_valid = wrapped_q || (rd_idx < wp_q);
  assign old_val  = rvalid_q ? ram_rdata : '0;

  // shared multiplier, operand picked by state
  assign mul_a  = (state_q == S_MUL1) ? old_val : v_q;
  assign prod_d = sad_pkg::PROD_BITS'(mul_a) *
                  sad_pkg::PROD_BITS'($signed({1'b0, gain_q}));
  assign scaled = $signed(prod_q[sad_pkg::PROD_BITS-1:sad_pkg::GAIN_BITS]);

  // feed-forward sum and stage output
  assign v_d = sad_pkg::sat(sad_pkg::SUM_BITS'(x_q) + sad_pkg::SUM_BITS'(scaled));
  assign x_d = sad_pkg::sat(sad_pkg::SUM_BITS'(old_q) - sad_pkg::SUM_BITS'(scaled));

  // buffer memory requests
  always_comb begin
    ram_req.re    = (state_q == S_READ);
    ram_req.raddr = {stage_q, rd_idx};
    ram_req.we    = (state_q == S_ADD1);
    ram_req.waddr = {stage_q, wp_q};
    ram_req.wdata = v_d;
  end

  sad_buffer_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = out_free &&
                    ((state_q == S_HOLD) || ((state_q == S_ADD2) && (stage_q == LastStage)));
  assign in_beat  = in_i.valid && in_i.ready;

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  // sequencer, write pointer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stage_q     <= '0;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            stage_q <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          rvalid_q <= rd_valid;
          state_q  <= S_MUL1;
        end
        S_MUL1: state_q <= S_ADD1;
        S_ADD1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_ADD2;
        S_ADD2: begin
          if (stage_q == LastStage) begin
            wp_q <= wp_q + 1'b1;
            if (wp_q == LastPtr) begin
              wrapped_q <= 1'b1;
            end
            if (out_free) begin
              out_valid_q <= 1'b1;
              out_data_q  <= x_d;
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_HOLD;
            end
          end else begin
            stage_q <= stage_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= x_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          x_q <= in_i.sample_in;
        end
      end
      S_MUL1: begin
        old_q  <= old_val;
        prod_q <= prod_d;
      end
      S_ADD1: v_q    <= v_d;
      S_MUL2: prod_q <= prod_d;
      S_ADD2: x_q    <= x_d;
      default: ;
    endcase
  end

  // checks
  a_accept_starts_stage0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == S_READ) && (stage_q == '0))
    else $error("accepted beat did not start at the first stage");

  a_no_ram_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("buffer read and write in the same cycle");

  a_wp_moves_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q != $past(wp_q)) |-> $past((state_q == S_ADD2) && (stage_q == LastStage)))
    else $error("write pointer moved outside the end of an item");

  a_result_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_ADD2) || ($past(state_q) == S_HOLD))
    else $error("result raised without a finished item");

endmodule
